// ----- hdl/osb_pkg.sv -----
// Shared types and codes for the one-shot timer bank.
`default_nettype none
package osb_pkg;

   // Request operation codes
   localparam logic [1:0] OP_SET     = 2'd0;
   localparam logic [1:0] OP_REMOVE  = 2'd1;
   localparam logic [1:0] OP_ADVANCE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_SETTLE,
      ST_FINISH,
      ST_REPORT
   } state_type;

   // Per-timer status from the head unit to the sequencer
   typedef struct packed {
      logic fire;
      logic cand_valid;
   } head_status_type;

endpackage
`default_nettype wire

// ----- hdl/one_shot_timer_bank.sv -----
// Top level of the one-shot timer bank: cell chain, head unit and sequencer.
//
// A bank of NUM_TIMERS one-shot timers held in a ring of cells. Each request
// (start high while busy is low) makes the ring rotate once, with the head
// unit updating each timer as it passes the front and folding its remaining
// time into a running minimum. Set interval, remove, an unused operation and
// an advance where nothing fires keep busy high for one rotation plus a settle
// and a finish step, and deliver one result in the first cycle with busy
// low. An advance where timers fire rotates the ring a second time to report
// them in index order: busy stays high through both rotations, and the fired
// transfers come one per fired timer, each in the cycle after its timer passes
// the front, so the one for the highest timer can land in the first cycle
// with busy low; the last one is marked by rsp_last with rsp_any_fired and
// rsp_next_timeout. Results are strobed for exactly one cycle; the receiver
// cannot stall them.
`default_nettype none
module one_shot_timer_bank #(
   parameter int NUM_TIMERS = 16,
   parameter int TIME_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [1:0]            req_operation,
   input  wire logic [3:0]            req_timer_index,
   input  wire logic [TIME_WIDTH-1:0] req_interval,
   input  wire logic [TIME_WIDTH-1:0] req_elapsed_time,
   output logic                       rsp_strobe,
   output logic                       rsp_fired,
   output logic      [3:0]            rsp_fired_index,
   output logic                       rsp_any_fired,
   output logic      [TIME_WIDTH-1:0] rsp_next_timeout,
   output logic                       rsp_last
);
   import osb_pkg::*;

   localparam int CNT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_TIMERS - 1);

   // ring contents
   logic [TIME_WIDTH-1:0] cell_tout [NUM_TIMERS];
   logic [TIME_WIDTH-1:0] cell_elap [NUM_TIMERS];
   logic                  cell_fire [NUM_TIMERS];

   // head output feeding the tail of the ring
   logic [TIME_WIDTH-1:0] head_tout;
   logic [TIME_WIDTH-1:0] head_elap;
   logic                  head_fire;
   logic [TIME_WIDTH-1:0] head_rem;
   head_status_type       head_st;

   logic                  shift_en;
   logic                  report_mode;
   logic                  is_target;

   // latched request
   logic [1:0]            op_ff;
   logic [3:0]            idx_ff;
   logic [TIME_WIDTH-1:0] interval_ff;
   logic [TIME_WIDTH-1:0] delta_ff;

   // sequencer state
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  any_ff, any_in;
   logic [CNT_W-1:0]      last_idx_ff, last_idx_in;
   logic                  cand_valid_ff, cand_valid_in;
   logic [TIME_WIDTH-1:0] cand_rem_ff, cand_rem_in;
   logic [TIME_WIDTH-1:0] min_ff, min_in;

   // result register
   logic                  strobe_ff, strobe_in;
   logic                  fired_ff, fired_in;
   logic [3:0]            fidx_ff, fidx_in;
   logic                  anyo_ff, anyo_in;
   logic [TIME_WIDTH-1:0] next_ff, next_in;
   logic                  lasto_ff, lasto_in;

   logic                  accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // ---------------- cell chain: cell i takes from cell i+1, tail from head
   for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
      logic [TIME_WIDTH-1:0] tin;
      logic [TIME_WIDTH-1:0] ein;
      logic                  fin;
      if (g == NUM_TIMERS - 1) begin : g_tail
         assign tin = head_tout;
         assign ein = head_elap;
         assign fin = head_fire;
      end else begin : g_mid
         assign tin = cell_tout[g+1];
         assign ein = cell_elap[g+1];
         assign fin = cell_fire[g+1];
      end
      osb_cell #(.TIME_WIDTH(TIME_WIDTH)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .timeout_i (tin),
         .elapsed_i (ein),
         .fired_i   (fin),
         .timeout_o (cell_tout[g]),
         .elapsed_o (cell_elap[g]),
         .fired_o   (cell_fire[g])
      );
   end

   // the timer at the chain front has index cnt_ff
   assign is_target = (32'(cnt_ff) == 32'(idx_ff));

   osb_head #(.TIME_WIDTH(TIME_WIDTH)) u_head (
      .op          (op_ff),
      .is_target   (is_target),
      .report_mode (report_mode),
      .interval    (interval_ff),
      .delta       (delta_ff),
      .timeout_i   (cell_tout[0]),
      .elapsed_i   (cell_elap[0]),
      .timeout_o   (head_tout),
      .elapsed_o   (head_elap),
      .fired_o     (head_fire),
      .rem_o       (head_rem),
      .status_o    (head_st)
   );

   // ---------------- request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_operation;
         idx_ff      <= req_timer_index;
         interval_ff <= req_interval;
         delta_ff    <= req_elapsed_time;
      end
   end

   // ---------------- sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         any_ff        <= 1'b0;
         last_idx_ff   <= '0;
         cand_valid_ff <= 1'b0;
         min_ff        <= '1;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         any_ff        <= any_in;
         last_idx_ff   <= last_idx_in;
         cand_valid_ff <= cand_valid_in;
         min_ff        <= min_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_rem_ff <= cand_rem_in;
      fired_ff    <= fired_in;
      fidx_ff     <= fidx_in;
      anyo_ff     <= anyo_in;
      next_ff     <= next_in;
      lasto_ff    <= lasto_in;
   end

   // ---------------- next state and result
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      any_in        = any_ff;
      last_idx_in   = last_idx_ff;
      cand_valid_in = 1'b0;
      cand_rem_in   = head_rem;
      // running minimum, one candidate per cycle, registered behind the head
      min_in        = (cand_valid_ff && (cand_rem_ff < min_ff)) ? cand_rem_ff : min_ff;
      shift_en      = 1'b0;
      report_mode   = 1'b0;
      strobe_in     = 1'b0;
      fired_in      = 1'b0;
      fidx_in       = '0;
      anyo_in       = 1'b0;
      next_in       = '0;
      lasto_in      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_WALK;
               cnt_in   = '0;
               any_in   = 1'b0;
               min_in   = '1;
            end
         end
         ST_WALK: begin
            shift_en      = 1'b1;
            cand_valid_in = head_st.cand_valid;
            if (head_st.fire) begin
               any_in      = 1'b1;
               last_idx_in = cnt_ff;
            end
            if (cnt_ff == CNT_LAST) begin
               cnt_in   = '0;
               state_in = ST_SETTLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SETTLE: begin
            // last candidate folds into the minimum here
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (any_ff) begin
               state_in = ST_REPORT;
            end else begin
               strobe_in = 1'b1;
               lasto_in  = 1'b1;
               next_in   = min_ff;
               state_in  = ST_IDLE;
            end
         end
         ST_REPORT: begin
            shift_en    = 1'b1;
            report_mode = 1'b1;
            if (cell_fire[0]) begin
               strobe_in = 1'b1;
               fired_in  = 1'b1;
               fidx_in   = 4'(cnt_ff);
               if (cnt_ff == last_idx_ff) begin
                  lasto_in = 1'b1;
                  anyo_in  = 1'b1;
                  next_in  = min_ff;
               end
            end
            if (cnt_ff == CNT_LAST) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_fired        = fired_ff;
   assign rsp_fired_index  = fidx_ff;
   assign rsp_any_fired    = anyo_ff;
   assign rsp_next_timeout = next_ff;
   assign rsp_last         = lasto_ff;

   // ---------------- assertions
   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_FINISH || $past(state_ff) == ST_REPORT))
      else $error("result transfer without a finishing or reporting step");

   a_fired_last_any: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last && rsp_fired) |-> rsp_any_fired)
      else $error("last fired transfer lacks any_fired");

   a_not_last_is_fired: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> (rsp_fired && !rsp_any_fired))
      else $error("non-final transfer does not report a fired timer");

   a_accept_starts_walk: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_WALK && cnt_ff == '0))
      else $error("accepted request did not start a ring pass");

   a_report_needs_fire: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPORT) |-> any_ff)
      else $error("report pass without any fired timer");
endmodule
`default_nettype wire

// ----- hdl/osb_cell.sv -----
// One timer cell of the rotating chain: timeout, elapsed count and fired flag.
`default_nettype none
module osb_cell #(
   parameter int TIME_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  shift_en,
   input  wire logic [TIME_WIDTH-1:0] timeout_i,
   input  wire logic [TIME_WIDTH-1:0] elapsed_i,
   input  wire logic                  fired_i,
   output logic      [TIME_WIDTH-1:0] timeout_o,
   output logic      [TIME_WIDTH-1:0] elapsed_o,
   output logic                       fired_o
);
   logic [TIME_WIDTH-1:0] timeout_ff;
   logic [TIME_WIDTH-1:0] elapsed_ff;
   logic                  fired_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= '1;
         elapsed_ff <= '0;
         fired_ff   <= 1'b0;
      end else if (shift_en) begin
         timeout_ff <= timeout_i;
         elapsed_ff <= elapsed_i;
         fired_ff   <= fired_i;
      end
   end

   assign timeout_o = timeout_ff;
   assign elapsed_o = elapsed_ff;
   assign fired_o   = fired_ff;
endmodule
`default_nettype wire

// ----- hdl/osb_head.sv -----
// Head unit: updates the timer leaving the front of the chain.
`default_nettype none
module osb_head #(
   parameter int TIME_WIDTH = 32
) (
   input  wire logic [1:0]            op,
   input  wire logic                  is_target,
   input  wire logic                  report_mode,
   input  wire logic [TIME_WIDTH-1:0] interval,
   input  wire logic [TIME_WIDTH-1:0] delta,
   input  wire logic [TIME_WIDTH-1:0] timeout_i,
   input  wire logic [TIME_WIDTH-1:0] elapsed_i,
   output logic      [TIME_WIDTH-1:0] timeout_o,
   output logic      [TIME_WIDTH-1:0] elapsed_o,
   output logic                       fired_o,
   output logic      [TIME_WIDTH-1:0] rem_o,
   output osb_pkg::head_status_type   status_o
);
   import osb_pkg::*;

   logic                  armed;
   logic [TIME_WIDTH-1:0] rem;
   logic [TIME_WIDTH:0]   diff;
   logic                  expire;

   assign armed  = (timeout_i != '1);
   assign rem    = timeout_i - elapsed_i;
   assign diff   = {1'b0, rem} - {1'b0, delta};
   // remaining <= delta: borrow out, or exact hit
   assign expire = diff[TIME_WIDTH] || (diff[TIME_WIDTH-1:0] == '0);

   always_comb begin
      timeout_o           = timeout_i;
      elapsed_o           = elapsed_i;
      fired_o             = 1'b0;
      rem_o               = rem;
      status_o.fire       = 1'b0;
      status_o.cand_valid = armed;
      if (report_mode) begin
         status_o.cand_valid = 1'b0;
      end else begin
         unique case (op)
            OP_SET: begin
               if (is_target) begin
                  timeout_o           = interval;
                  elapsed_o           = '0;
                  rem_o               = interval;
                  status_o.cand_valid = (interval != '1);
               end
            end
            OP_REMOVE: begin
               if (is_target) begin
                  timeout_o           = '1;
                  elapsed_o           = '0;
                  status_o.cand_valid = 1'b0;
               end
            end
            OP_ADVANCE: begin
               if (armed && expire) begin
                  timeout_o           = '1;
                  fired_o             = 1'b1;
                  status_o.fire       = 1'b1;
                  status_o.cand_valid = 1'b0;
               end else if (armed) begin
                  elapsed_o = elapsed_i + delta;
                  rem_o     = diff[TIME_WIDTH-1:0];
               end
            end
            default: begin
            end
         endcase
      end
      if (!report_mode && op != OP_ADVANCE) begin
         fired_o = 1'b0;
      end
      if (report_mode) begin
         fired_o = 1'b0;
      end
   end
endmodule
`default_nettype wire
